>>> design/rsame_pkg.sv
package rsame_pkg;

  // port width of the data fields
  localparam int DATA_W = 64;
  // datapath width, 8 to 64
  localparam int WIDTH  = 64;
  localparam int CNT_W  = $clog2(WIDTH);
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_EXPONENT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MODULUS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEY_READY = 2'd2;

  // (x + y) mod m for x, y < m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] sum;
    logic [WIDTH:0] dif;
    sum = {1'b0, x} + {1'b0, y};
    dif = sum - {1'b0, m};
    if (sum >= {1'b0, m}) begin
      return dif[WIDTH-1:0];
    end
    return sum[WIDTH-1:0];
  endfunction

endpackage

>>> design/rsame_modmul.sv
module rsame_modmul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rsame_pkg::WIDTH-1:0]  a_in,
  input  logic [rsame_pkg::WIDTH-1:0]  b_in,
  input  logic [rsame_pkg::WIDTH-1:0]  m_in,
  output logic                         done,
  output logic [rsame_pkg::WIDTH-1:0]  prod
);
  import rsame_pkg::*;

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] p_r, p_nxt;

  // shift-and-add over the bits of b, low bit first
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      a_nxt   = a_in;
      b_nxt   = b_in;
      p_nxt   = '0;
    end else if (run_r) begin
      if (b_r[0]) begin
        p_nxt = add_mod(p_r, a_r, m_in);
      end
      a_nxt   = add_mod(a_r, a_r, m_in);
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WIDTH - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

>>> design/rsa_modular_exponentiation_core.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  in_cipher_block, in_last_block
// out      output     out_valid/out_ready  out_plain_block, out_last_out, out_error_flag
// cfg      input      cfg_wr_en            cfg_index, cfg_wdata
//
// one request at a time: the block is first reduced modulo the modulus, then for each
// exponent bit up to the highest set one, the result is multiplied by the square when
// the bit is set and the square is then squared, both in the one bit-serial modmul unit
// key not ready or modulus below two: no computation, zero result with error flag set
// the result waits in an output register; a new request is taken meanwhile
// rst_n is synchronous; it clears control state and the configuration registers
module rsa_modular_exponentiation_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rsame_pkg::DATA_W-1:0]  in_cipher_block,
  input  logic                          in_last_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsame_pkg::DATA_W-1:0]  out_plain_block,
  output logic                          out_last_out,
  output logic                          out_error_flag,
  input  logic                          cfg_wr_en,
  input  logic [rsame_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rsame_pkg::DATA_W-1:0]  cfg_wdata
);
  import rsame_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_STEP   = 5'b00100,
    S_MUL    = 5'b01000,
    S_SQR    = 5'b10000
  } state_t;

  // S_STEP with a zero exponent also finishes; hold_r keeps the result until it moves out
  state_t           state_r, state_nxt;
  logic             hold_r, hold_nxt;
  logic [WIDTH-1:0] exp_r, mod_r;
  logic             key_r;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] sq_r, sq_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] plain_r;
  logic             plain_last_r, plain_err_r;
  logic             load_out;
  logic             in_acc;
  logic             bad_key;
  logic [WIDTH:0]   rem;
  logic [WIDTH:0]   rem_sub;
  logic             mm_start;
  logic [WIDTH-1:0] mm_a;
  logic             mm_done;
  logic [WIDTH-1:0] mm_p;

  rsame_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a_in  (mm_a),
    .b_in  (sq_r),
    .m_in  (mod_r),
    .done  (mm_done),
    .prod  (mm_p)
  );

  assign in_ready = (state_r == S_IDLE) && !hold_r;
  assign in_acc   = in_valid && in_ready;
  assign bad_key  = !key_r || (mod_r[WIDTH-1:1] == '0);
  assign load_out = hold_r && (!out_valid_r || out_ready);

  // one remainder bit per cycle, block bits from the top
  assign rem     = {sq_r, acc_r[WIDTH-1]};
  assign rem_sub = rem - {1'b0, mod_r};

  assign mm_a = (state_r == S_STEP && e_r[0]) ? acc_r : sq_r;

  always_comb begin
    state_nxt = state_r;
    hold_nxt  = hold_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    e_nxt     = e_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    err_nxt   = err_r;
    mm_start  = 1'b0;
    if (load_out) begin
      hold_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_last_block;
          if (bad_key) begin
            acc_nxt  = '0;
            err_nxt  = 1'b1;
            hold_nxt = 1'b1;
          end else begin
            err_nxt   = 1'b0;
            acc_nxt   = in_cipher_block[WIDTH-1:0];
            sq_nxt    = '0;
            e_nxt     = exp_r;
            cnt_nxt   = '0;
            state_nxt = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        sq_nxt  = (rem >= {1'b0, mod_r}) ? rem_sub[WIDTH-1:0] : rem[WIDTH-1:0];
        acc_nxt = acc_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          acc_nxt   = WIDTH'(1);
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (e_r == '0) begin
          hold_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mm_start  = 1'b1;
          state_nxt = e_r[0] ? S_MUL : S_SQR;
        end
      end
      S_MUL: begin
        if (mm_done) begin
          acc_nxt   = mm_p;
          mm_start  = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          sq_nxt    = mm_p;
          e_nxt     = e_r >> 1;
          state_nxt = S_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      exp_r       <= '0;
      mod_r       <= '0;
      key_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_EXPONENT:  exp_r <= cfg_wdata[WIDTH-1:0];
          REG_MODULUS:   mod_r <= cfg_wdata[WIDTH-1:0];
          REG_KEY_READY: key_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    sq_r   <= sq_nxt;
    e_r    <= e_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
    if (load_out) begin
      plain_r      <= acc_r;
      plain_last_r <= last_r;
      plain_err_r  <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_plain_block = DATA_W'(plain_r);
  assign out_last_out    = plain_last_r;
  assign out_error_flag  = plain_err_r;

endmodule

>>> design/rsame_checker.sv
module rsame_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rsame_pkg::DATA_W-1:0]  out_plain_block,
  input logic                          out_error_flag
);
  import rsame_pkg::*;

  // a result waiting on the sink stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_plain_block == '0)
    else $error("error result with nonzero value");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rsa_modular_exponentiation_core rsame_checker u_rsame_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_plain_block (out_plain_block),
  .out_error_flag  (out_error_flag)
);
